### design/yaz0_stream_decompressor_macros.svh
`ifndef YAZ0_STREAM_DECOMPRESSOR_MACROS_SVH
`define YAZ0_STREAM_DECOMPRESSOR_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define YZ0_ASSERT_SAME(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define YZ0_ASSERT_NEXT(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### design/yz0_pkg.sv
`default_nettype none

package yz0_pkg;

   localparam int WINDOW_BYTES_DEF     = 4096;
   localparam int BYTES_PER_RESULT_DEF = 8;

   localparam int OUT_BYTES_W  = 64;
   localparam int OUT_COUNT_W  = 4;
   localparam int SIZE_W       = 32;
   localparam int RSP_TDATA_W  = 104;

   // Header layout: the decoded size sits in bytes 4 to 7, big-endian.
   localparam logic [3:0] HDR_SIZE_FIRST = 4'd4;
   localparam logic [3:0] HDR_SIZE_LAST  = 4'd7;
   localparam logic [3:0] HDR_LAST       = 4'd15;

   localparam logic [3:0] FLAG_GROUP_SIZE = 4'd8;
   localparam logic [8:0] LEN_SHORT_BIAS  = 9'd2;
   localparam logic [8:0] LEN_LONG_BIAS   = 9'd18;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_ITEM,
      PH_REF_SECOND,
      PH_REF_THIRD,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CP_IDLE,
      CP_READ,
      CP_TAIL,
      CP_FLUSH
   } copy_state_type;

   typedef enum logic [1:0] {
      CMD_RESTART,
      CMD_LIT,
      CMD_COPY,
      CMD_EMPTY
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [8:0]   length;
      logic [11:0]  dist_m1;
      logic         fin;
      logic         trunc;
   } copy_cmd_type;

   typedef struct packed {
      logic [OUT_BYTES_W-1:0] bytes;
      logic [OUT_COUNT_W-1:0] count;
      logic                   last;
      logic                   done;
      logic                   trunc;
   } result_type;

endpackage

`default_nettype wire

### design/yz0_ram.sv
`default_nettype none

module yz0_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/yz0_parser.sv
`default_nettype none

module yz0_parser import yz0_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    in_byte,
   input  wire logic          in_start,
   output copy_cmd_type       cmd,
   output logic [SIZE_W-1:0]  size_value
);

   phase_type          phase_ff, phase_in;
   logic [3:0]         hidx_ff, hidx_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [7:0]         flag_ff, flag_in;
   logic [3:0]         fleft_ff, fleft_in;
   logic [7:0]         held_ff, held_in;
   logic [11:0]        dist_ff, dist_in;

   logic [8:0]         sub_len;
   logic [SIZE_W:0]    rem_diff;
   logic               rem_zero;
   logic               go_copy;
   logic [11:0]        go_dist;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hidx_ff  <= '0;
         size_ff  <= '0;
         rem_ff   <= '0;
         flag_ff  <= '0;
         fleft_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         size_ff  <= size_in;
         rem_ff   <= rem_in;
         flag_ff  <= flag_in;
         fleft_ff <= fleft_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      dist_ff <= dist_in;
   end

   always_comb begin
      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      size_in  = size_ff;
      rem_in   = rem_ff;
      flag_in  = flag_ff;
      fleft_in = fleft_ff;
      held_in  = held_ff;
      dist_in  = dist_ff;
      cmd      = '0;
      go_copy  = 1'b0;
      go_dist  = dist_ff;

      // One subtractor serves literals and references: its borrow tells a
      // reference that overruns the remaining size.
      unique case (phase_ff)
         PH_REF_SECOND: sub_len = 9'(held_ff[7:4]) + LEN_SHORT_BIAS;
         PH_REF_THIRD:  sub_len = 9'(in_byte) + LEN_LONG_BIAS;
         default:       sub_len = 9'd1;
      endcase
      rem_diff = {1'b0, rem_ff} - (SIZE_W+1)'(sub_len);
      rem_zero = (rem_diff[SIZE_W-1:0] == '0);

      if (accept && in_start) begin
         // The start byte is header byte 0 and carries no size bits.
         phase_in   = PH_HEADER;
         hidx_in    = 4'd1;
         size_in    = '0;
         rem_in     = '0;
         flag_in    = '0;
         fleft_in   = '0;
         cmd.valid  = 1'b1;
         cmd.kind   = CMD_RESTART;
      end else if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hidx_ff >= HDR_SIZE_FIRST && hidx_ff <= HDR_SIZE_LAST) begin
                  size_in = {size_ff[SIZE_W-9:0], in_byte};
               end
               hidx_in = hidx_ff + 4'd1;
               if (hidx_ff == HDR_LAST) begin
                  rem_in = size_in;
                  if (size_in == '0) begin
                     phase_in  = PH_DONE;
                     cmd.valid = 1'b1;
                     cmd.kind  = CMD_EMPTY;
                     cmd.fin   = 1'b1;
                  end else begin
                     phase_in = PH_ITEM;
                  end
               end
            end
            PH_ITEM: begin
               if (fleft_ff == '0) begin
                  flag_in  = in_byte;
                  fleft_in = FLAG_GROUP_SIZE;
               end else if (flag_ff[7]) begin
                  flag_in   = {flag_ff[6:0], 1'b0};
                  fleft_in  = fleft_ff - 4'd1;
                  rem_in    = rem_diff[SIZE_W-1:0];
                  cmd.valid = 1'b1;
                  cmd.kind  = CMD_LIT;
                  cmd.data  = in_byte;
                  cmd.fin   = rem_zero;
                  if (rem_zero) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  held_in  = in_byte;
                  phase_in = PH_REF_SECOND;
               end
            end
            PH_REF_SECOND: begin
               go_dist = {held_ff[3:0], in_byte};
               dist_in = go_dist;
               if (held_ff[7:4] != 4'd0) begin
                  go_copy = 1'b1;
               end else begin
                  phase_in = PH_REF_THIRD;
               end
            end
            PH_REF_THIRD: begin
               go_copy = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (go_copy) begin
         flag_in   = {flag_ff[6:0], 1'b0};
         if (fleft_ff != '0) begin
            fleft_in = fleft_ff - 4'd1;
         end
         cmd.valid = 1'b1;
         if (rem_diff[SIZE_W]) begin
            cmd.kind  = CMD_EMPTY;
            cmd.fin   = 1'b1;
            cmd.trunc = 1'b1;
            phase_in  = PH_DONE;
         end else begin
            rem_in      = rem_diff[SIZE_W-1:0];
            cmd.kind    = CMD_COPY;
            cmd.length  = sub_len;
            cmd.dist_m1 = go_dist;
            cmd.fin     = rem_zero;
            phase_in    = rem_zero ? PH_DONE : PH_ITEM;
         end
      end
   end

   assign size_value = size_ff;

endmodule

`default_nettype wire

### design/yz0_copy.sv
`default_nettype none

module yz0_copy import yz0_pkg::*; #(
   parameter int WINDOW_BYTES     = WINDOW_BYTES_DEF,
   parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire copy_cmd_type  cmd,
   output logic               busy,
   output logic               res_valid,
   output result_type         res,
   input  wire logic          res_ready
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam int CW = $clog2(BYTES_PER_RESULT + 1);
   localparam int LW = BYTES_PER_RESULT * 8;
   localparam logic [AW:0]   WIN      = (AW+1)'(WINDOW_BYTES);
   localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_BYTES - 1);
   localparam logic [CW-1:0] CHUNK_LAST = CW'(BYTES_PER_RESULT - 1);

   copy_state_type   state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW-1:0]    src_ff, src_in;
   logic [8:0]       left_ff, left_in;
   logic [CW-1:0]    iss_ff, iss_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [LW-1:0]    acc_ff, acc_in;
   logic [7:0]       last_byte_ff, last_byte_in;
   logic             dist_one_ff, dist_one_in;
   logic             fin_ff, fin_in;
   logic             trunc_ff, trunc_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [7:0]       ram_rdata;
   logic [7:0]       copy_byte;
   logic [AW:0]      src_diff;
   logic [AW-1:0]    src_start;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      return (a == WIN_LAST) ? '0 : a + AW'(1);
   endfunction

   yz0_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_BYTES)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (src_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CP_IDLE;
         wp_ff    <= '0;
         pend_ff  <= 1'b0;
         left_ff  <= '0;
         iss_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         pend_ff  <= pend_in;
         left_ff  <= left_in;
         iss_ff   <= iss_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      acc_ff       <= acc_in;
      last_byte_ff <= last_byte_in;
      dist_one_ff  <= dist_one_in;
      fin_ff       <= fin_in;
      trunc_ff     <= trunc_in;
   end

   // Start of a copy: the write position minus the distance, modulo the window.
   always_comb begin
      src_diff = {1'b0, wp_ff} - (AW+1)'(cmd.dist_m1) - (AW+1)'(1);
      if (src_diff[AW]) begin
         src_start = AW'(src_diff + WIN);
      end else begin
         src_start = AW'(src_diff);
      end
   end

   // With a distance of one, the byte that the read returns was written only
   // in this very cycle, so the previous copied byte is used instead.
   assign copy_byte = (dist_one_ff && cnt_ff != '0) ? last_byte_ff : ram_rdata;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      iss_in       = iss_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      acc_in       = acc_ff;
      last_byte_in = last_byte_ff;
      dist_one_in  = dist_one_ff;
      fin_in       = fin_ff;
      trunc_in     = trunc_ff;
      ram_we       = 1'b0;
      ram_waddr    = wp_ff;
      ram_wdata    = copy_byte;
      ram_re       = 1'b0;
      res_valid    = 1'b0;
      res          = '0;

      // Data of the read issued in the previous cycle lands here.
      if (pend_ff) begin
         ram_we       = 1'b1;
         wp_in        = wrap_inc(wp_ff);
         cnt_in       = cnt_ff + CW'(1);
         last_byte_in = copy_byte;
         for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            if (cnt_ff == CW'(i)) begin
               acc_in[i*8 +: 8] = copy_byte;
            end
         end
      end

      unique case (state_ff)
         CP_IDLE: begin
            if (cmd.valid) begin
               unique case (cmd.kind)
                  CMD_RESTART: begin
                     wp_in = '0;
                  end
                  CMD_LIT: begin
                     ram_we    = 1'b1;
                     ram_wdata = cmd.data;
                     wp_in     = wrap_inc(wp_ff);
                     res_valid = 1'b1;
                     res.bytes = OUT_BYTES_W'(cmd.data);
                     res.count = OUT_COUNT_W'(1);
                     res.last  = 1'b1;
                     res.done  = cmd.fin;
                     if (!res_ready) begin
                        acc_in   = LW'(cmd.data);
                        cnt_in   = CW'(1);
                        left_in  = '0;
                        fin_in   = cmd.fin;
                        trunc_in = 1'b0;
                        state_in = CP_FLUSH;
                     end
                  end
                  CMD_EMPTY: begin
                     res_valid = 1'b1;
                     res.last  = 1'b1;
                     res.done  = 1'b1;
                     res.trunc = cmd.trunc;
                     if (!res_ready) begin
                        acc_in   = '0;
                        cnt_in   = '0;
                        left_in  = '0;
                        fin_in   = 1'b1;
                        trunc_in = cmd.trunc;
                        state_in = CP_FLUSH;
                     end
                  end
                  CMD_COPY: begin
                     src_in      = src_start;
                     left_in     = cmd.length;
                     dist_one_in = (cmd.dist_m1 == '0);
                     fin_in      = cmd.fin;
                     trunc_in    = 1'b0;
                     acc_in      = '0;
                     cnt_in      = '0;
                     iss_in      = '0;
                     state_in    = CP_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         CP_READ: begin
            ram_re  = 1'b1;
            pend_in = 1'b1;
            src_in  = wrap_inc(src_ff);
            left_in = left_ff - 9'd1;
            iss_in  = iss_ff + CW'(1);
            if (left_ff == 9'd1 || iss_ff == CHUNK_LAST) begin
               state_in = CP_TAIL;
            end
         end
         CP_TAIL: begin
            state_in = CP_FLUSH;
         end
         CP_FLUSH: begin
            res_valid = 1'b1;
            res.bytes = OUT_BYTES_W'(acc_ff);
            res.count = OUT_COUNT_W'(cnt_ff);
            res.last  = (left_ff == '0);
            res.done  = fin_ff && (left_ff == '0);
            res.trunc = trunc_ff;
            if (res_ready) begin
               acc_in   = '0;
               cnt_in   = '0;
               iss_in   = '0;
               state_in = (left_ff == '0) ? CP_IDLE : CP_READ;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != CP_IDLE);

endmodule

`default_nettype wire

### design/yaz0_stream_decompressor.sv
`default_nettype none

// Yaz0 decoder fed one compressed byte per input item, starting with the
// 16-byte header marked by req_tuser; decoded bytes leave in results of up to
// BYTES_PER_RESULT bytes, lowest lane first, with tlast on the last result of
// each literal or reference and tuser flagging the end of the stream and a
// truncation. Header, flag and reference bytes, and literals, are taken while
// the copy unit is idle. A back-reference keeps the input stalled while its
// bytes are copied, since the history window memory has one read port that
// returns one byte a cycle and each result chunk adds a drain state (CP_TAIL)
// and a hand-off state (CP_FLUSH). A stall on the result side holds the copy.
// The history window is not cleared at reset; a stream must not reference
// bytes that were never written.
module yaz0_stream_decompressor import yz0_pkg::*; #(
   parameter int WINDOW_BYTES     = WINDOW_BYTES_DEF,
   parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // data_byte
   input  wire logic                   req_tuser,   // stream_start
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_bytes [63:0], out_count [67:64], decoded_size [99:68], zeros above
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,   // run_last
   output logic [1:0]                  rsp_tuser    // stream_done [0], truncated [1]
);

   copy_cmd_type       cmd;
   logic [SIZE_W-1:0]  size_value;
   logic               copy_busy;
   logic               res_valid;
   result_type         res;
   logic               res_ready;
   logic               accept;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;

   assign req_tready = !copy_busy;
   assign accept     = req_tvalid && req_tready;

   yz0_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .in_start   (req_tuser),
      .cmd        (cmd),
      .size_value (size_value)
   );

   yz0_copy #(
      .WINDOW_BYTES     (WINDOW_BYTES),
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_copy (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .busy      (copy_busy),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // Output register: the copy unit may hand over a new item while the
   // current one is being taken.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_size_in  = rsp_size_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_res_in  = res;
            rsp_size_in = res.done ? size_value : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-OUT_BYTES_W-OUT_COUNT_W-SIZE_W)'(0),
                        rsp_size_ff, rsp_res_ff.count, rsp_res_ff.bytes};
   assign rsp_tlast  = rsp_res_ff.last;
   assign rsp_tuser  = {rsp_res_ff.trunc, rsp_res_ff.done};

`include "yaz0_stream_decompressor_macros.svh"

   `YZ0_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid_ff, rsp_res_ff.count <= OUT_COUNT_W'(BYTES_PER_RESULT), "result holds more bytes than a chunk")

   `YZ0_ASSERT_SAME(a_mid_chunk_full, clock, reset, rsp_valid_ff && !rsp_res_ff.last, rsp_res_ff.count == OUT_COUNT_W'(BYTES_PER_RESULT), "result before the last of an item is not full")

   `YZ0_ASSERT_SAME(a_trunc_shape, clock, reset, rsp_valid_ff && rsp_res_ff.trunc, rsp_res_ff.done && rsp_res_ff.last && rsp_res_ff.count == '0, "truncated result is not an empty final result")

   `YZ0_ASSERT_NEXT(a_copy_blocks, clock, reset, cmd.valid && cmd.kind == CMD_COPY, !req_tready, "input not stalled after a back-reference started")

endmodule

`default_nettype wire

### tb/yaz0_stream_decompressor_tb.sv
`timescale 1ns / 100ps

import yz0_pkg::*;

typedef struct {
   logic [63:0] bytes;
   logic [3:0]  count;
   logic        last;
   logic        done;
   logic        trunc;
   logic [31:0] total;
} decoded_chunk_type;

class yaz0_scoreboard;
   bit [7:0]          window [WINDOW_BYTES_DEF];
   bit                written [WINDOW_BYTES_DEF];
   bit [11:0]         wr_pos;
   longint            left;
   bit [7:0]          flags;
   int                flags_left;
   phase_type         phase;
   int                hdr_idx;
   bit [7:0]          ref_first;
   int                ref_dist;
   bit [31:0]         size_field;
   decoded_chunk_type pending_chunks[$];
   int                errors;

   function new();
      phase = PH_IDLE;
      errors = 0;
   endfunction

   function void push_chunk(bit [63:0] bytes, bit [3:0] count, bit last, bit done,
                            bit trunc);
      decoded_chunk_type c;
      c.bytes = bytes;
      c.count = count;
      c.last  = last;
      c.done  = done;
      c.trunc = trunc;
      c.total = done ? size_field : 32'd0;
      pending_chunks.push_back(c);
   endfunction

   function void store_byte(bit [7:0] b);
      window[wr_pos] = b;
      written[wr_pos] = 1'b1;
      wr_pos++;
   endfunction

   // True when every byte that a copy reads from before its own output was written.
   function bit span_written(int distance, int len);
      bit [11:0] idx;
      for (int k = 0; k < len && k < distance; k++) begin
         idx = wr_pos - 12'(distance) + 12'(k);
         if (!written[idx]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function void copy_bytes(int len);
      bit [63:0] acc;
      int        cnt;
      bit        fin;
      bit [7:0]  b;
      flags = flags << 1;
      if (flags_left > 0) flags_left--;
      if (len > left) begin
         phase = PH_DONE;
         push_chunk(64'd0, 4'd0, 1'b1, 1'b1, 1'b1);
         return;
      end
      fin = (left == len);
      acc = 64'd0;
      cnt = 0;
      for (int i = 0; i < len; i++) begin
         // A distance of the full window wraps to the current position.
         b = window[wr_pos - ref_dist[11:0]];
         store_byte(b);
         acc |= 64'(b) << (8 * cnt);
         cnt++;
         if (cnt == BYTES_PER_RESULT_DEF) begin
            push_chunk(acc, 4'(cnt), i == len - 1, fin && i == len - 1, 1'b0);
            acc = 64'd0;
            cnt = 0;
         end
      end
      if (cnt > 0) push_chunk(acc, 4'(cnt), 1'b1, fin, 1'b0);
      left -= len;
      phase = fin ? PH_DONE : PH_ITEM;
   endfunction

   function void take_byte(bit [7:0] b, bit start);
      if (start) begin
         wr_pos = 12'd0;
         left = 0;
         flags = 8'd0;
         flags_left = 0;
         hdr_idx = 0;
         ref_first = 8'd0;
         ref_dist = 0;
         size_field = 32'd0;
         phase = PH_HEADER;
      end else if (phase == PH_IDLE || phase == PH_DONE) begin
         return;
      end
      case (phase)
         PH_HEADER: begin
            if (hdr_idx >= HDR_SIZE_FIRST && hdr_idx <= HDR_SIZE_LAST)
               size_field = {size_field[23:0], b};
            if (hdr_idx == HDR_LAST) begin
               left = size_field;
               phase = PH_ITEM;
               if (left == 0) begin
                  phase = PH_DONE;
                  push_chunk(64'd0, 4'd0, 1'b1, 1'b1, 1'b0);
               end
            end
            hdr_idx++;
         end
         PH_ITEM: begin
            if (flags_left == 0) begin
               flags = b;
               flags_left = int'(FLAG_GROUP_SIZE);
            end else if (flags[7]) begin
               store_byte(b);
               left--;
               flags = flags << 1;
               flags_left--;
               if (left == 0) phase = PH_DONE;
               push_chunk(64'(b), 4'd1, 1'b1, left == 0, 1'b0);
            end else begin
               ref_first = b;
               phase = PH_REF_SECOND;
            end
         end
         PH_REF_SECOND: begin
            ref_dist = {ref_first[3:0], b} + 1;
            if (ref_first[7:4] != 4'd0)
               copy_bytes(int'(ref_first[7:4]) + int'(LEN_SHORT_BIAS));
            else
               phase = PH_REF_THIRD;
         end
         PH_REF_THIRD: copy_bytes(int'(b) + int'(LEN_LONG_BIAS));
         default: ;
      endcase
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_chunk(logic [RSP_TDATA_W-1:0] data, logic last, logic [1:0] user);
      decoded_chunk_type e;
      if (pending_chunks.size() == 0) begin
         $error("unexpected result item: tdata %0h", data);
         errors++;
         return;
      end
      e = pending_chunks.pop_front();
      compare_field("out_bytes", e.bytes, data[63:0]);
      compare_field("out_count", 64'(e.count), 64'(data[67:64]));
      compare_field("run_last", 64'(e.last), 64'(last));
      compare_field("stream_done", 64'(e.done), 64'(user[0]));
      compare_field("truncated", 64'(e.trunc), 64'(user[1]));
      compare_field("decoded_size", 64'(e.total), 64'(data[99:68]));
   endfunction
endclass

module yaz0_stream_decompressor_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int MIN_REF_LEN = 3;
   localparam int MAX_REF_LEN = 273;
   localparam int MAX_DIST    = 4096;
   localparam int ITEM_TARGET = 420;
   localparam int LONG_HOLD   = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic [1:0]             rsp_tuser;

   yaz0_scoreboard sb = new();
   int             items_sent = 0;
   int             send_calm = 0;
   int             recv_calm = 0;
   bit             long_hold_due = 1'b0;
   int unsigned    cycle_count = 0;

   yaz0_stream_decompressor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_chunk(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // Random waits, broken up now and then by a stretch with no waits.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 6);
   endfunction

   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(negedge clock);
         hold = draw_gap(recv_calm);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_byte(input bit [7:0] b, input bit start, input bit counted);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(b, start);
      if (counted) items_sent++;
   endtask

   // Bytes sent while no stream is open; the block drops them.
   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   // Sends the first upto header bytes; the magic and padding bytes are random.
   task automatic send_header(input bit [31:0] total, input int upto);
      bit [7:0] b;
      for (int i = 0; i < upto; i++) begin
         if (i >= HDR_SIZE_FIRST && i <= HDR_SIZE_LAST)
            b = total[8 * (7 - i) + 7 -: 8];
         else
            b = 8'($urandom);
         send_byte(b, i == 0, 1'b1);
      end
   endtask

   task automatic send_ref_bytes(input int len, input int distance);
      bit [11:0] dm1;
      dm1 = 12'(distance - 1);
      if (len < LEN_LONG_BIAS) begin
         send_byte({4'(len - LEN_SHORT_BIAS), dm1[11:8]}, 1'b0, 1'b1);
         send_byte(dm1[7:0], 1'b0, 1'b1);
      end else begin
         send_byte({4'h0, dm1[11:8]}, 1'b0, 1'b1);
         send_byte(dm1[7:0], 1'b0, 1'b1);
         send_byte(8'(len - LEN_LONG_BIAS), 1'b0, 1'b1);
      end
   endtask

   // Picks a reference that only reads written history, or one that overruns
   // the size. Gives up on the stream when neither is possible.
   task automatic send_random_ref(output bit abandon);
      longint rem;
      int     len;
      int     distance;
      int     maxl;
      int     wp;
      bit     trunc;
      bit     found;
      abandon = 1'b0;
      rem = sb.left;
      wp = int'(sb.wr_pos);
      trunc = (rem < MIN_REF_LEN) || (rem < MAX_REF_LEN && $urandom_range(0, 19) == 0);
      found = 1'b0;
      if (!trunc) begin
         maxl = (rem < MAX_REF_LEN) ? int'(rem) : MAX_REF_LEN;
         case ($urandom_range(0, 2))
            0: len = $urandom_range(MIN_REF_LEN, maxl < 17 ? maxl : 17);
            1: len = $urandom_range(MIN_REF_LEN, maxl);
            default: len = maxl;
         endcase
         for (int t = 0; t < 16 && !found; t++) begin
            if (t % 4 == 3 || wp == 0)
               distance = $urandom_range(1, MAX_DIST);
            else if (t % 2 == 0)
               distance = $urandom_range(1, wp < 8 ? wp : 8);
            else
               distance = $urandom_range(1, wp);
            found = sb.span_written(distance, len);
         end
         if (!found) begin
            if (rem >= MAX_REF_LEN) begin
               abandon = 1'b1;
               return;
            end
            trunc = 1'b1;
         end
      end
      if (trunc) begin
         len = $urandom_range(rem + 1 > MIN_REF_LEN ? int'(rem) + 1 : MIN_REF_LEN,
                              MAX_REF_LEN);
         distance = $urandom_range(1, MAX_DIST);
      end
      send_ref_bytes(len, distance);
   endtask

   task automatic send_random_stream();
      bit [31:0] total;
      int        sel;
      int        style;
      int        upto;
      int        give_up_after;
      int        stream_items;
      bit        first;
      bit        abandon;
      bit [7:0]  flags;
      sel = $urandom_range(0, 99);
      style = $urandom_range(0, 2);
      if (sel < 5) begin
         total = 32'd0;
      end else if (sel < 10) begin
         total = $urandom_range(2000, 4600);
         style = 1;
      end else if (sel < 30) begin
         total = $urandom_range(65, 700);
      end else begin
         total = $urandom_range(1, 64);
      end
      upto = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 15) : 16;
      send_header(total, upto);
      if (upto < 16) return;
      give_up_after = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 20) : 32'h7fffffff;
      stream_items = 0;
      first = 1'b1;
      while (sb.phase == PH_ITEM && stream_items < give_up_after &&
             items_sent < ITEM_TARGET) begin
         case (style)
            0: flags = 8'($urandom | $urandom);
            1: flags = 8'($urandom & $urandom);
            default: flags = 8'($urandom);
         endcase
         // Opening with literals gives later references some history to read.
         if (first && total >= 2000) flags = 8'hff;
         else if (first && $urandom_range(0, 4) != 0) flags[7] = 1'b1;
         first = 1'b0;
         send_byte(flags, 1'b0, 1'b1);
         stream_items++;
         for (int i = 7; i >= 0 && sb.phase == PH_ITEM; i--) begin
            if (flags[i]) begin
               send_byte(8'($urandom), 1'b0, 1'b1);
            end else begin
               send_random_ref(abandon);
               if (abandon) return;
            end
            stream_items++;
         end
      end
      if (sb.phase == PH_DONE && $urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
   endtask

   initial begin
      bit second_hold;
      second_hold = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bytes before any stream start are dropped.
      send_noise(2);
      // Zero decoded size ends the stream right after the header.
      send_header(32'd0, 16);
      // Largest size, cut off by a restart in the middle of a flag group.
      send_header(32'hffff_ffff, 16);
      send_byte(8'hff, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hff, 1'b0, 1'b1);
      send_byte(8'ha5, 1'b0, 1'b1);
      // Literals, then short and long references, each overlapping its own output.
      send_header(32'd40, 16);
      send_byte(8'hc0, 1'b0, 1'b1);
      send_byte(8'h5a, 1'b0, 1'b1);
      send_byte(8'h3c, 1'b0, 1'b1);
      send_ref_bytes(3, 1);
      send_ref_bytes(17, 2);
      send_ref_bytes(18, 5);
      send_noise(1);
      // Longest reference, then one that overruns what is left.
      send_header(32'd300, 16);
      send_byte(8'h80, 1'b0, 1'b1);
      send_byte(8'h81, 1'b0, 1'b1);
      send_ref_bytes(MAX_REF_LEN, 1);
      send_ref_bytes(MAX_REF_LEN, 7);

      long_hold_due = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         if (!second_hold && items_sent >= 250) begin
            long_hold_due = 1'b1;
            second_hold = 1'b1;
         end
         send_random_stream();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.pending_chunks.size() != 0) @(posedge clock);
      repeat (360) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/yz0_pkg.sv
design/yz0_ram.sv
design/yz0_parser.sv
design/yz0_copy.sv
design/yaz0_stream_decompressor.sv
tb/yaz0_stream_decompressor_tb.sv
